[rtl/core/aapr_pkg.sv]
// Shared constants, types and arithmetic helpers for the axis-angle point rotation block.
`default_nettype none
package aapr_pkg;

    localparam int CORDIC_STEPS_DEF = 24;
    localparam int CFG_IDX_W        = 3;
    localparam int ACC_W            = 40;
    localparam int CRD_W            = 34;
    localparam int ANG_W            = 33;
    localparam int DIFF_W           = 33;
    // every product operand (axis terms, 1-c, sine, entries, offsets) fits in 34 bits
    localparam int MUL_W            = 34;

    typedef logic signed [ACC_W-1:0] t_acc;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_AXIS_X   = 3'd0,
        CFG_AXIS_Y   = 3'd1,
        CFG_AXIS_Z   = 3'd2,
        CFG_CENTER_X = 3'd3,
        CFG_CENTER_Y = 3'd4,
        CFG_CENTER_Z = 3'd5,
        CFG_DIM      = 3'd6
    } t_cfg_idx;

    localparam t_acc Q30_ONE     = 40'sd1073741824;
    localparam t_acc Q30_HALF    = 40'sd536870912;
    localparam t_acc Q30_PI      = 40'sd3373259426;
    localparam t_acc Q30_TWO_PI  = 40'sd6746518852;
    localparam t_acc Q30_HALF_PI = 40'sd1686629713;
    localparam t_acc Q30_INV_G   = 40'sd652032874;
    localparam t_acc S32_MAX     = 40'sd2147483647;
    localparam t_acc S32_MIN     = -40'sd2147483648;

    function automatic logic signed [31:0] atan_q30(input logic [4:0] idx);
        logic signed [31:0] v;
        unique case (idx)
            5'd0:  v = 32'sd843314857;
            5'd1:  v = 32'sd497837829;
            5'd2:  v = 32'sd263043837;
            5'd3:  v = 32'sd133525159;
            5'd4:  v = 32'sd67021687;
            5'd5:  v = 32'sd33543516;
            5'd6:  v = 32'sd16775851;
            5'd7:  v = 32'sd8388437;
            5'd8:  v = 32'sd4194283;
            5'd9:  v = 32'sd2097149;
            5'd31: v = 32'sd1;
            default: v = 32'sd1 <<< (5'd30 - idx);
        endcase
        return v;
    endfunction

    // Q30 product, round half up
    function automatic t_acc mulq(input t_acc a, input t_acc b);
        logic signed [2*MUL_W-1:0] p;
        p = $signed(a[MUL_W-1:0]) * $signed(b[MUL_W-1:0]) + (2*MUL_W)'(Q30_HALF);
        p = p >>> 30;
        return p[ACC_W-1:0];
    endfunction

    function automatic t_acc sat(input t_acc v, input t_acc lo, input t_acc hi);
        t_acc r;
        if (v < lo) r = lo;
        else if (v > hi) r = hi;
        else r = v;
        return r;
    endfunction

endpackage
`default_nettype wire

[rtl/core/axis_angle_point_rotation.sv]
// Top level: Rodrigues rotation of a streamed point about a configured axis and centre.
//
//  channel | dir | handshake                  | content
//  s       | in  | i_s_tvalid / o_s_tready    | angle, pos_x, pos_y, pos_z
//  m       | out | o_m_tvalid / i_m_tready    | disp_x, disp_y, disp_z
//  cfg     | in  | i_cfg_we                   | register index, write data
//
// One point per cycle while the m side does not stall; the path is angle reduction, the CORDIC
// pipeline (one iteration per stage) and its quadrant fold, two matrix stages, product and sum.
// Synchronous active-low reset clears the stage valids and the centre registers, loads the
// axis with +Z and the dimension with 3; o_s_tready stays low while reset is held.
// A stall on the m side freezes every stage; nothing is dropped or repeated.
`default_nettype none
module axis_angle_point_rotation #(
    parameter int CORDIC_STEPS = aapr_pkg::CORDIC_STEPS_DEF
) (
    input  wire          i_clk,
    input  wire          i_rst_n,
    input  wire          i_s_tvalid,
    output logic         o_s_tready,
    input  wire  [127:0] i_s_tdata,  // angle, pos_x, pos_y, pos_z
    output logic         o_m_tvalid,
    input  wire          i_m_tready,
    output logic [95:0]  o_m_tdata,  // disp_x, disp_y, disp_z
    input  wire          i_cfg_we,
    input  wire  [aapr_pkg::CFG_IDX_W-1:0] i_cfg_idx,
    input  wire  [31:0]  i_cfg_data
);
    localparam int AW = aapr_pkg::ACC_W;
    localparam int DW = aapr_pkg::DIFF_W;
    localparam int CW = aapr_pkg::CRD_W;
    localparam int ZW = aapr_pkg::ANG_W;

    logic signed [31:0] r_axis [3];
    logic signed [31:0] r_ctr  [3];
    logic [1:0]         r_dim;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_axis[0] <= '0;
            r_axis[1] <= '0;
            r_axis[2] <= 32'sh4000_0000;
            r_ctr[0]  <= '0;
            r_ctr[1]  <= '0;
            r_ctr[2]  <= '0;
            r_dim     <= 2'd3;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                aapr_pkg::CFG_AXIS_X:   r_axis[0] <= i_cfg_data;
                aapr_pkg::CFG_AXIS_Y:   r_axis[1] <= i_cfg_data;
                aapr_pkg::CFG_AXIS_Z:   r_axis[2] <= i_cfg_data;
                aapr_pkg::CFG_CENTER_X: r_ctr[0]  <= i_cfg_data;
                aapr_pkg::CFG_CENTER_Y: r_ctr[1]  <= i_cfg_data;
                aapr_pkg::CFG_CENTER_Z: r_ctr[2]  <= i_cfg_data;
                aapr_pkg::CFG_DIM:      r_dim     <= i_cfg_data[1:0];
                default: ;
            endcase
        end
    end

    // axis terms follow the registers; config is to change only while idle, not enforced here
    aapr_pkg::t_acc r_n [3];
    aapr_pkg::t_acc r_nn [6]; // xx yy zz xy xz yz
    always_ff @(posedge i_clk) begin
        for (int k = 0; k < 3; k++) begin
            r_n[k] <= aapr_pkg::sat(AW'(r_axis[k]), -aapr_pkg::Q30_ONE, aapr_pkg::Q30_ONE);
        end
        r_nn[0] <= aapr_pkg::mulq(r_n[0], r_n[0]);
        r_nn[1] <= aapr_pkg::mulq(r_n[1], r_n[1]);
        r_nn[2] <= aapr_pkg::mulq(r_n[2], r_n[2]);
        r_nn[3] <= aapr_pkg::mulq(r_n[0], r_n[1]);
        r_nn[4] <= aapr_pkg::mulq(r_n[0], r_n[2]);
        r_nn[5] <= aapr_pkg::mulq(r_n[1], r_n[2]);
    end

    logic w_en;
    assign w_en       = !o_m_tvalid || i_m_tready;
    assign o_s_tready = i_rst_n && w_en;

    // stage 0: angle reduction and offsets from the centre
    aapr_pkg::t_acc     w_a0, w_a1, w_a2;
    logic               w_neg;
    logic               r0_v, r0_neg;
    logic signed [ZW-1:0] r0_z;
    logic [3*DW-1:0]    r0_d;
    always_comb begin
        w_a0 = AW'($signed(i_s_tdata[31:0])) <<< 2;
        w_a1 = w_a0 > aapr_pkg::Q30_PI ? w_a0 - aapr_pkg::Q30_TWO_PI :
               (w_a0 < -aapr_pkg::Q30_PI ? w_a0 + aapr_pkg::Q30_TWO_PI : w_a0);
        w_neg = 1'b1;
        if (w_a1 > aapr_pkg::Q30_HALF_PI) w_a2 = w_a1 - aapr_pkg::Q30_PI;
        else if (w_a1 < -aapr_pkg::Q30_HALF_PI) w_a2 = w_a1 + aapr_pkg::Q30_PI;
        else begin
            w_a2  = w_a1;
            w_neg = 1'b0;
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r0_v <= 1'b0;
        end else if (w_en) begin
            r0_v <= i_s_tvalid;
        end
        if (w_en) begin
            r0_z   <= w_a2[ZW-1:0];
            r0_neg <= w_neg;
            for (int k = 0; k < 3; k++) begin
                r0_d[k*DW +: DW] <= DW'($signed(i_s_tdata[32*(k+1) +: 32])) - DW'(r_ctr[k]);
            end
        end
    end

    logic               c_v;
    logic signed [CW-1:0] c_cos, c_sin;
    logic [3*DW-1:0]    c_d;
    aapr_cordic #(.STEPS(CORDIC_STEPS), .TAG_W(3*DW)) u_cordic (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_en    (w_en),
        .i_valid (r0_v),
        .i_z     (r0_z),
        .i_neg   (r0_neg),
        .i_tag   (r0_d),
        .o_valid (c_v),
        .o_cos   (c_cos),
        .o_sin   (c_sin),
        .o_tag   (c_d)
    );

    // stage 1: (1-c) n n^T and s n
    aapr_pkg::t_acc r1_m [6];
    aapr_pkg::t_acc r1_s [3];
    aapr_pkg::t_acc r1_cs, w_t;
    logic [3*DW-1:0] r1_d;
    logic           r1_v;
    assign w_t = aapr_pkg::Q30_ONE - AW'(c_cos);
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r1_v <= 1'b0;
        end else if (w_en) begin
            r1_v <= c_v;
        end
        if (w_en) begin
            for (int k = 0; k < 6; k++) r1_m[k] <= aapr_pkg::mulq(r_nn[k], w_t);
            for (int k = 0; k < 3; k++) r1_s[k] <= aapr_pkg::mulq(r_n[k], AW'(c_sin));
            r1_cs <= AW'(c_cos);
            r1_d  <= c_d;
        end
    end

    // stage 2: matrix entries, clamped to one
    aapr_pkg::t_acc w_r [9];
    aapr_pkg::t_acc r2_r [9];
    logic [3*DW-1:0] r2_d;
    logic           r2_v;
    always_comb begin
        w_r[0] = r1_m[0] + r1_cs;
        w_r[1] = r1_m[3] - r1_s[2];
        w_r[2] = r1_m[4] + r1_s[1];
        w_r[3] = r1_m[3] + r1_s[2];
        w_r[4] = r1_m[1] + r1_cs;
        w_r[5] = r1_m[5] - r1_s[0];
        w_r[6] = r1_m[4] - r1_s[1];
        w_r[7] = r1_m[5] + r1_s[0];
        w_r[8] = r1_m[2] + r1_cs;
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r2_v <= 1'b0;
        end else if (w_en) begin
            r2_v <= r1_v;
        end
        if (w_en) begin
            for (int k = 0; k < 9; k++) begin
                r2_r[k] <= aapr_pkg::sat(w_r[k], -aapr_pkg::Q30_ONE, aapr_pkg::Q30_ONE);
            end
            r2_d <= r1_d;
        end
    end

    // stage 3: R_ij * d_j, columns beyond the dimension dropped
    aapr_pkg::t_acc r3_p [9];
    logic [3*DW-1:0] r3_d;
    logic           r3_v;
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r3_v <= 1'b0;
        end else if (w_en) begin
            r3_v <= r2_v;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                for (int j = 0; j < 3; j++) begin
                    r3_p[3*i+j] <= (j < int'(r_dim)) ?
                        aapr_pkg::mulq(r2_r[3*i+j], AW'($signed(r2_d[j*DW +: DW]))) : '0;
                end
            end
            r3_d <= r2_d;
        end
    end

    // stage 4: sum, back to displacement, saturate, outputs beyond the dimension zeroed
    aapr_pkg::t_acc w_sum [3];
    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sum[i] = r3_p[3*i] + r3_p[3*i+1] + r3_p[3*i+2]
                     - AW'($signed(r3_d[i*DW +: DW]));
        end
    end
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_m_tvalid <= 1'b0;
        end else if (w_en) begin
            o_m_tvalid <= r3_v;
        end
        if (w_en) begin
            for (int i = 0; i < 3; i++) begin
                o_m_tdata[32*i +: 32] <= (i < int'(r_dim)) ?
                    32'(aapr_pkg::sat(w_sum[i], aapr_pkg::S32_MIN, aapr_pkg::S32_MAX)) : 32'd0;
            end
        end
    end
endmodule
`default_nettype wire

[rtl/core/aapr_cordic.sv]
// Pipelined rotation-mode CORDIC, one iteration per register stage, with a travelling tag.
`default_nettype none
module aapr_cordic #(
    parameter int STEPS = aapr_pkg::CORDIC_STEPS_DEF,
    parameter int TAG_W = 1
) (
    input  wire                              i_clk,
    input  wire                              i_rst_n,
    input  wire                              i_en,
    input  wire                              i_valid,
    input  wire  signed [aapr_pkg::ANG_W-1:0] i_z,
    input  wire                              i_neg,
    input  wire        [TAG_W-1:0]           i_tag,
    output logic                             o_valid,
    output logic signed [aapr_pkg::CRD_W-1:0] o_cos,
    output logic signed [aapr_pkg::CRD_W-1:0] o_sin,
    output logic       [TAG_W-1:0]           o_tag
);
    localparam int CW = aapr_pkg::CRD_W;
    localparam int AW = aapr_pkg::ANG_W;

    logic              r_v   [1:STEPS];
    logic signed [CW-1:0] r_x [1:STEPS];
    logic signed [CW-1:0] r_y [1:STEPS];
    logic signed [AW-1:0] r_z [1:STEPS];
    logic              r_neg [1:STEPS];
    logic [TAG_W-1:0]  r_tag [1:STEPS];

    for (genvar g = 0; g < STEPS; g++) begin : g_iter
        logic                 w_v, w_neg;
        logic signed [CW-1:0] w_x, w_y;
        logic signed [AW-1:0] w_z;
        logic [TAG_W-1:0]     w_tag;
        logic signed [CW-1:0] n_x, n_y;
        logic signed [AW-1:0] n_z, w_atan;
        if (g == 0) begin : g_head
            assign w_v   = i_valid;
            assign w_x   = CW'(aapr_pkg::Q30_INV_G);
            assign w_y   = '0;
            assign w_z   = i_z;
            assign w_neg = i_neg;
            assign w_tag = i_tag;
        end else begin : g_body
            assign w_v   = r_v[g];
            assign w_x   = r_x[g];
            assign w_y   = r_y[g];
            assign w_z   = r_z[g];
            assign w_neg = r_neg[g];
            assign w_tag = r_tag[g];
        end
        assign w_atan = AW'(aapr_pkg::atan_q30(5'(g)));
        always_comb begin
            if (!w_z[AW-1]) begin
                n_x = w_x - (w_y >>> g);
                n_y = w_y + (w_x >>> g);
                n_z = w_z - w_atan;
            end else begin
                n_x = w_x + (w_y >>> g);
                n_y = w_y - (w_x >>> g);
                n_z = w_z + w_atan;
            end
        end
        always_ff @(posedge i_clk) begin
            if (!i_rst_n) begin
                r_v[g+1] <= 1'b0;
            end else if (i_en) begin
                r_v[g+1] <= w_v;
            end
            if (i_en) begin
                r_x[g+1]   <= n_x;
                r_y[g+1]   <= n_y;
                r_z[g+1]   <= n_z;
                r_neg[g+1] <= w_neg;
                r_tag[g+1] <= w_tag;
            end
        end
    end

    // quadrant fold undone here
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            o_valid <= 1'b0;
        end else if (i_en) begin
            o_valid <= r_v[STEPS];
        end
        if (i_en) begin
            o_cos <= r_neg[STEPS] ? -r_x[STEPS] : r_x[STEPS];
            o_sin <= r_neg[STEPS] ? -r_y[STEPS] : r_y[STEPS];
            o_tag <= r_tag[STEPS];
        end
    end
endmodule
`default_nettype wire

[rtl/core/aapr_checker.sv]
// Port-level checks for the rotation block, bound to the top level.
`default_nettype none
module aapr_checker (
    input wire         i_clk,
    input wire         i_rst_n,
    input wire         o_s_tready,
    input wire         o_m_tvalid,
    input wire         i_m_tready,
    input wire [95:0]  o_m_tdata
);
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |=> o_m_tvalid && $stable(o_m_tdata))
        else $error("result changed while stalled");

    a_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_m_tvalid || i_m_tready |-> o_s_tready)
        else $error("input refused with free output");

    a_rst: assert property (@(posedge i_clk)
        !i_rst_n |=> !o_m_tvalid)
        else $error("result after reset");

    a_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_m_tvalid && !i_m_tready |-> !o_s_tready)
        else $error("input taken during output stall");
endmodule

bind axis_angle_point_rotation aapr_checker u_aapr_checker (
    .i_clk      (i_clk),
    .i_rst_n    (i_rst_n),
    .o_s_tready (o_s_tready),
    .o_m_tvalid (o_m_tvalid),
    .i_m_tready (i_m_tready),
    .o_m_tdata  (o_m_tdata)
);
`default_nettype wire
